FILE: design/pfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the particle frame animator
// Request and result payloads, register indexes, generator constants and
// the control structs of the iterative remainder unit.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANIM_ENABLED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_FRAME    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_PLAYBACK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_STEP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED     = 3'd5;

  // request operations
  localparam logic OP_BIRTH   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // xorshift64* constants
  localparam int unsigned   XS_SHIFT_A = 12;
  localparam int unsigned   XS_SHIFT_B = 25;
  localparam int unsigned   XS_SHIFT_C = 27;
  localparam logic [63:0]   RNG_MUL    = 64'd2685821657736338717;
  localparam logic [31:0]   RNG_MUL_LO = RNG_MUL[31:0];
  localparam logic [31:0]   RNG_MUL_HI = RNG_MUL[63:32];

  // remainder unit geometry
  localparam int unsigned DIV_DVD_W = 32;
  localparam int unsigned DIV_DVS_W = 16;

  // request payload
  typedef struct packed {
    logic        op;
    logic [15:0] frame_in;
    logic        reverse_in;
  } in_item_t;

  // result payload
  typedef struct packed {
    logic [15:0] frame_out;
    logic        reverse_out;
  } out_item_t;

  // remainder unit control
  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } pfa_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVS_W-1:0] rem;
  } pfa_div_rsp_t;

endpackage

FILE: design/pfa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_div: iterative remainder unit
// Restoring shift-subtract, one dividend bit per cycle; pulses done with the
// remainder once all dividend bits are consumed.
// ----------------------------------------------------------------------------
module pfa_div
  import pfa_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pfa_div_req_t req_i,
  output pfa_div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_DVD_W - 1);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIV_DVD_W-1:0] dvd_q, dvd_d;
  logic [DIV_DVS_W-1:0] dvs_q, dvs_d;
  logic [DIV_DVS_W-1:0] rem_q, rem_d;
  logic [DIV_DVS_W:0]   trial;

  // one shift-subtract step
  assign trial = {rem_q, dvd_q[DIV_DVD_W-1]};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = req_i.dividend;
      dvs_d = req_i.divisor;
      rem_d = '0;
    end else if (run_q) begin
      dvd_d = {dvd_q[DIV_DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DIV_DVS_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[DIV_DVS_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: design/particle_frame_animator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_frame_animator: sprite frame animation with xorshift64* draws
// Updates one particle frame code (frame index times 255) per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid_i / in_data_i and are taken when in_stall_o
//   is low; one result per request leaves on out_valid_o / out_data_o and is
//   taken when out_stall_i is low. Registers are written through cfg_we_i,
//   cfg_idx_i and cfg_wdata_i while no request is in flight.
//   One request is worked on at a time; in_stall_o is low only when idle.
//   Sequencer path from request taken to result leaving for the output:
//     birth without draws or disabled advance: done state directly
//     advance: advance state, the remainder unit only for a wrap, done
//     birth with only a direction draw: xorshift, M0 to M3, use, done
//     birth with random frame: the same draw, then the remainder unit,
//     and a second draw before done when a direction draw is also due
//   The 32-step remainder unit and the 32x32 multiplier, used three times
//   per draw, make up the longer paths.
//   A result waits in the output register while the receiver stalls; the
//   next request is already taken meanwhile and holds in its last step.
//   Reset clears the configuration registers and the output valid to zero
//   except frame_count (one), loads the generator state with one, and leaves the datapath registers unreset.
// ----------------------------------------------------------------------------
module particle_frame_animator
  import pfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_ADV  = 10'b0000000010,
    S_XS   = 10'b0000000100,
    S_M0   = 10'b0000001000,
    S_M1   = 10'b0000010000,
    S_M2   = 10'b0000100000,
    S_M3   = 10'b0001000000,
    S_USE  = 10'b0010000000,
    S_DIV  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  typedef enum logic [2:0] {
    USE_BIRTH = 3'b001,
    USE_OVER  = 3'b010,
    USE_UNDER = 3'b100
  } use_e;

  state_e state_q, state_d;
  use_e   use_q, use_d;

  // configuration
  logic        anim_q, rfrm_q, rplay_q;
  logic [8:0]  fcount_q;
  logic [16:0] fstep_q;
  logic [63:0] rng_q, rng_d;

  // working registers
  logic               draw_frame_q, draw_frame_d;
  logic [15:0]        frame_q, frame_d;
  logic               rev_q, rev_d;
  logic signed [17:0] c_q, c_d;
  logic [15:0]        m_q, m_d;
  logic [8:0]         cnt_q, cnt_d;
  logic [63:0]        prod_q, prod_d;
  logic [31:0]        acc_q, acc_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic         accept;
  logic [8:0]   eff_cnt;
  logic [16:0]  m_full;
  logic [63:0]  xs1, xs2, xs3;
  logic [31:0]  mul_a, mul_b;
  logic signed [17:0] frame_ext, step_ext, c_m1, c_neg;
  logic         over, under;
  logic [7:0]   rem8;
  pfa_div_req_t div_req;
  pfa_div_rsp_t div_rsp;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // effective frame count and wrap modulus count*255
  always_comb begin
    if (fcount_q == 9'd0) begin
      eff_cnt = 9'd1;
    end else if (fcount_q[8] && (fcount_q[7:0] != 8'd0)) begin
      eff_cnt = 9'd256;
    end else begin
      eff_cnt = fcount_q;
    end
  end
  assign m_full = {eff_cnt, 8'd0} - {8'd0, eff_cnt};

  // moved frame code
  assign frame_ext = $signed({2'b00, in_data_i.frame_in});
  assign step_ext  = $signed({fstep_q[16], fstep_q});

  // xorshift step
  assign xs1 = rng_q ^ (rng_q >> XS_SHIFT_A);
  assign xs2 = xs1 ^ (xs1 << XS_SHIFT_B);
  assign xs3 = xs2 ^ (xs2 >> XS_SHIFT_C);

  // shared 32x32 multiplier operand select
  always_comb begin
    unique case (state_q)
      S_M0:    begin mul_a = rng_q[31:0];  mul_b = RNG_MUL_LO; end
      S_M1:    begin mul_a = rng_q[63:32]; mul_b = RNG_MUL_LO; end
      default: begin mul_a = rng_q[31:0];  mul_b = RNG_MUL_HI; end
    endcase
  end
  assign prod_d = mul_a * mul_b;

  // wrap classification
  assign over  = c_q > $signed({2'b00, m_q});
  assign under = c_q[17];
  assign c_m1  = c_q - 18'sd1;
  assign c_neg = -c_q;
  assign rem8  = div_rsp.rem[7:0];

  // remainder unit requests
  always_comb begin
    div_req = '0;
    if (state_q == S_USE && draw_frame_q) begin
      div_req.start    = 1'b1;
      div_req.dividend = acc_q;
      div_req.divisor  = {7'd0, cnt_q};
    end else if (state_q == S_ADV && (over || under)) begin
      div_req.start    = 1'b1;
      div_req.dividend = over ? {14'd0, c_m1} : {14'd0, c_neg};
      div_req.divisor  = m_q;
    end
  end

  pfa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    use_d        = use_q;
    draw_frame_d = draw_frame_q;
    rng_d        = rng_q;
    frame_d      = frame_q;
    rev_d        = rev_q;
    c_d          = c_q;
    m_d          = m_q;
    cnt_d        = cnt_q;
    acc_d        = acc_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          frame_d = in_data_i.frame_in;
          rev_d   = in_data_i.reverse_in;
          c_d     = in_data_i.reverse_in ? (frame_ext - step_ext) : (frame_ext + step_ext);
          m_d     = m_full[15:0];
          cnt_d   = eff_cnt;
          if (in_data_i.op == OP_BIRTH) begin
            if (rfrm_q) begin
              draw_frame_d = 1'b1;
              state_d      = S_XS;
            end else if (anim_q && rplay_q) begin
              draw_frame_d = 1'b0;
              state_d      = S_XS;
            end else begin
              state_d = S_DONE;
            end
          end else if (anim_q) begin
            state_d = S_ADV;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_ADV: begin
        if (over) begin
          use_d   = USE_OVER;
          state_d = S_DIV;
        end else if (under) begin
          use_d   = USE_UNDER;
          state_d = S_DIV;
        end else begin
          frame_d = c_q[15:0];
          state_d = S_DONE;
        end
      end
      S_XS: begin
        rng_d   = xs3;
        state_d = S_M0;
      end
      S_M0: begin
        state_d = S_M1;
      end
      S_M1: begin
        acc_d   = prod_q[63:32];
        state_d = S_M2;
      end
      S_M2: begin
        acc_d   = acc_q + prod_q[31:0];
        state_d = S_M3;
      end
      S_M3: begin
        acc_d   = acc_q + prod_q[31:0];
        state_d = S_USE;
      end
      S_USE: begin
        if (draw_frame_q) begin
          use_d   = USE_BIRTH;
          state_d = S_DIV;
        end else begin
          rev_d   = rev_q | acc_q[0];
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          unique case (use_q)
            USE_BIRTH: begin
              frame_d = {rem8, 8'd0} - {8'd0, rem8};
              if (anim_q && rplay_q) begin
                draw_frame_d = 1'b0;
                state_d      = S_XS;
              end else begin
                state_d = S_DONE;
              end
            end
            USE_OVER: begin
              frame_d = div_rsp.rem + 16'd1;
              state_d = S_DONE;
            end
            USE_UNDER: begin
              frame_d = (div_rsp.rem == 16'd0) ? 16'd0 : (m_q - div_rsp.rem);
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.frame_out   = frame_q;
          out_d.reverse_out = rev_q;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // seed write reloads the generator
    if (cfg_we_i && cfg_idx_i == CFG_RANDOM_SEED) begin
      rng_d = (cfg_wdata_i == 64'd0) ? 64'd1 : cfg_wdata_i;
    end
  end

  // control and configuration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      use_q        <= USE_BIRTH;
      draw_frame_q <= 1'b0;
      out_valid_q  <= 1'b0;
      rng_q        <= 64'd1;
      anim_q       <= 1'b0;
      rfrm_q       <= 1'b0;
      rplay_q      <= 1'b0;
      fcount_q     <= 9'd1;
      fstep_q      <= '0;
    end else begin
      state_q      <= state_d;
      use_q        <= use_d;
      draw_frame_q <= draw_frame_d;
      out_valid_q  <= out_valid_d;
      rng_q        <= rng_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ANIM_ENABLED:    anim_q   <= cfg_wdata_i[0];
          CFG_RANDOM_FRAME:    rfrm_q   <= cfg_wdata_i[0];
          CFG_RANDOM_PLAYBACK: rplay_q  <= cfg_wdata_i[0];
          CFG_FRAME_COUNT:     fcount_q <= cfg_wdata_i[8:0];
          CFG_FRAME_STEP:      fstep_q  <= cfg_wdata_i[16:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    rev_q   <= rev_d;
    c_q     <= c_d;
    m_q     <= m_d;
    cnt_q   <= cnt_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
